// ===== rtl/dfpe_pkg.sv =====
// Shared types, constants and helpers for the DShot frame pulse encoder.
package dfpe_pkg;

  localparam int GapWordsDefault = 4;
  localparam int ChannelsDefault = 8;
  localparam int DataBits        = 16;
  localparam int JobDepth        = 2;

  localparam logic [15:0] OneHighReset   = 16'd30;
  localparam logic [15:0] ZeroHighReset  = 16'd15;
  localparam logic [10:0] ThrLimitReset  = 11'd1999;

  typedef enum logic [1:0] {
    CFG_ONE_HIGH  = 2'd0,
    CFG_ZERO_HIGH = 2'd1,
    CFG_THR_LIMIT = 2'd2
  } cfg_reg_e;

  // Decoded job handed from the front end to the serialiser.
  typedef struct packed {
    logic        err;
    logic [2:0]  channel;
    logic [15:0] frame;
  } dfpe_job_t;

  typedef struct packed {
    logic [15:0] one_high;
    logic [15:0] zero_high;
  } dfpe_widths_t;

  // 12-bit word (value plus zero telemetry bit) followed by its nibble XOR.
  function automatic logic [15:0] build_frame(logic [10:0] val);
    logic [11:0] w;
    logic [3:0]  crc;
    w   = {val, 1'b0};
    crc = w[3:0] ^ w[7:4] ^ w[11:8];
    return {w, crc};
  endfunction

endpackage

// ===== rtl/dfpe_front.sv =====
// Front end: accepts items, checks range and limit, builds the 16-bit frame.
module dfpe_front #(
  parameter int Channels = dfpe_pkg::ChannelsDefault
) (
  input  logic                push_i,
  output logic                full_o,
  input  logic [10:0]         throttle_i,
  input  logic [5:0]          command_i,
  input  logic [2:0]          channel_i,
  input  logic [10:0]         throttle_limit_i,
  input  logic                job_full_i,
  output logic                job_push_o,
  output dfpe_pkg::dfpe_job_t job_o
);

  logic        chan_ok;
  logic [10:0] sum;

  assign full_o  = job_full_i;
  assign chan_ok = (32'(channel_i) < 32'(Channels));
  // wraps to 11 bits by construction
  assign sum     = throttle_i + 11'(command_i);

  assign job_push_o    = push_i && !job_full_i && chan_ok;
  assign job_o.err     = (throttle_i > throttle_limit_i);
  assign job_o.channel = channel_i;
  assign job_o.frame   = dfpe_pkg::build_frame(sum);

endmodule

// ===== rtl/dfpe_job_fifo.sv =====
// Short job queue between the front end and the serialiser.
module dfpe_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dfpe_pkg::dfpe_job_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dfpe_pkg::dfpe_job_t rdata_o
);

  localparam int Depth = dfpe_pkg::JobDepth;
  localparam int PtrW  = $clog2(Depth);

  dfpe_pkg::dfpe_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/dfpe_back.sv =====
// Serialiser: turns a job into bit-slot compare widths plus gap words.
module dfpe_back #(
  parameter int GapWords = dfpe_pkg::GapWordsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dfpe_pkg::dfpe_widths_t widths_i,
  input  logic                   job_empty_i,
  input  dfpe_pkg::dfpe_job_t    job_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [2:0]             out_channel_o,
  output logic [15:0]            pulse_width_o,
  output logic                   last_word_o,
  output logic                   status_o
);

  localparam int Total = dfpe_pkg::DataBits + GapWords;
  localparam int CntW  = $clog2(Total);
  localparam logic [CntW-1:0] LastCnt = CntW'(Total - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     shift_q, shift_d;
  logic [2:0]      chan_q, chan_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_chan_q, out_chan_d;
  logic [15:0]     out_width_q, out_width_d;
  logic            out_last_q, out_last_d;
  logic            out_status_q, out_status_d;

  logic            adv, load, emit, in_data;
  logic [15:0]     src_shift;
  logic [CntW-1:0] src_cnt;
  logic [2:0]      src_chan;

  assign adv       = !out_valid_q || pop_i;
  assign load      = adv && !busy_q && !job_empty_i;
  assign emit      = adv && (busy_q || !job_empty_i);
  assign job_pop_o = load;

  always_comb begin
    src_shift = busy_q ? shift_q : job_i.frame;
    src_cnt   = busy_q ? cnt_q : '0;
    src_chan  = busy_q ? chan_q : job_i.channel;
    in_data   = ({1'b0, src_cnt} < (CntW+1)'(dfpe_pkg::DataBits));
  end

  always_comb begin
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    chan_d       = chan_q;
    out_valid_d  = adv ? emit : out_valid_q;
    out_chan_d   = out_chan_q;
    out_width_d  = out_width_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (emit) begin
      out_chan_d = src_chan;
      if (load && job_i.err) begin
        // rejected item: single error word, serialiser stays free
        out_width_d  = '0;
        out_last_d   = 1'b1;
        out_status_d = 1'b1;
      end else begin
        out_status_d = 1'b0;
        out_last_d   = (src_cnt == LastCnt);
        if (in_data) begin
          out_width_d = src_shift[15] ? widths_i.one_high : widths_i.zero_high;
        end else begin
          out_width_d = '0;
        end
        busy_d  = (src_cnt != LastCnt);
        cnt_d   = src_cnt + CntW'(1);
        shift_d = {src_shift[14:0], 1'b0};
        chan_d  = src_chan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    shift_q      <= shift_d;
    chan_q       <= chan_d;
    out_chan_q   <= out_chan_d;
    out_width_q  <= out_width_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign empty_o       = !out_valid_q;
  assign out_channel_o = out_chan_q;
  assign pulse_width_o = out_width_q;
  assign last_word_o   = out_last_q;
  assign status_o      = out_status_q;

  a_err_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q |-> out_last_q && (out_width_q == '0))
    else $error("error word not a lone zero-width last word");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> !busy_q)
    else $error("job taken while a frame is still being serialised");

  a_busy_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !busy_d |-> emit && out_last_d)
    else $error("serialiser released without emitting the last word");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_width_q) && $stable(out_last_q))
    else $error("pending output word changed while stalled");

endmodule

// ===== rtl/dshot_frame_pulse_encoder_unit.sv =====
// Top level of the DShot frame pulse encoder: config registers and the pipeline.
// Each accepted item with a channel below CHANNELS turns into 16 + GAP_WORDS
// result words (20 by default), MSB of the 16-bit DShot frame first, or into
// a single error word when the throttle is above the limit. The serialiser
// emits one word per clock while the output is not stalled by pop_i, and it
// takes a new item only once the last word of a frame is out; a two-entry job
// queue lets the next items be taken while a frame is still going out. On an
// idle block the first word is on the outputs from the clock edge after the
// one that accepts the item. Write the configuration registers only while no
// frame is in flight.
module dshot_frame_pulse_encoder_unit #(
  parameter int GAP_WORDS = dfpe_pkg::GapWordsDefault,
  parameter int CHANNELS  = dfpe_pkg::ChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [10:0] throttle_i,
  input  logic [5:0]  command_i,
  input  logic [2:0]  channel_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  out_channel_o,
  output logic [15:0] pulse_width_o,
  output logic        last_word_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dfpe_pkg::dfpe_widths_t widths_q, widths_d;
  logic [10:0]            thr_limit_q, thr_limit_d;

  dfpe_pkg::dfpe_job_t push_job, head_job;
  logic                job_push, job_full, job_pop, job_empty;

  always_comb begin
    widths_d    = widths_q;
    thr_limit_d = thr_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfpe_pkg::CFG_ONE_HIGH:  widths_d.one_high  = cfg_data_i;
        dfpe_pkg::CFG_ZERO_HIGH: widths_d.zero_high = cfg_data_i;
        dfpe_pkg::CFG_THR_LIMIT: thr_limit_d        = cfg_data_i[10:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widths_q.one_high  <= dfpe_pkg::OneHighReset;
      widths_q.zero_high <= dfpe_pkg::ZeroHighReset;
      thr_limit_q        <= dfpe_pkg::ThrLimitReset;
    end else begin
      widths_q    <= widths_d;
      thr_limit_q <= thr_limit_d;
    end
  end

  dfpe_front #(
    .Channels(CHANNELS)
  ) u_front (
    .push_i          (push_i),
    .full_o          (full_o),
    .throttle_i      (throttle_i),
    .command_i       (command_i),
    .channel_i       (channel_i),
    .throttle_limit_i(thr_limit_q),
    .job_full_i      (job_full),
    .job_push_o      (job_push),
    .job_o           (push_job)
  );

  dfpe_job_fifo u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(push_job),
    .full_o (job_full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .rdata_o(head_job)
  );

  dfpe_back #(
    .GapWords(GAP_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .widths_i     (widths_q),
    .job_empty_i  (job_empty),
    .job_i        (head_job),
    .job_pop_o    (job_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_channel_o(out_channel_o),
    .pulse_width_o(pulse_width_o),
    .last_word_o  (last_word_o),
    .status_o     (status_o)
  );

endmodule
